// ===== sv/imds_pkg.sv =====
// imds_pkg: item types, queue entry type and byte/tag codes for the image metadata stripper
// used by every module of the block; no dependencies

package imds_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       status;
        logic       run_last;
    } t_out;

    localparam int CMD_BYTES = 12;

    // results caused by one accepted item: kept bytes, then an optional end item
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [3:0]                cnt;
        logic                      has_end;
        logic                      end_status;
    } t_cmd;

    localparam logic       KIND_DATA  = 1'b0;
    localparam logic       KIND_END   = 1'b1;
    localparam logic       ST_SCRUBBED = 1'b0;
    localparam logic       ST_UNSUPPORTED = 1'b1;

    localparam logic [7:0] B_PNG_MAGIC = 8'h89;
    localparam logic [7:0] B_MARK      = 8'hFF;
    localparam logic [7:0] B_SOI       = 8'hD8;
    localparam logic [7:0] B_SOS       = 8'hDA;
    localparam logic [7:0] B_APP_LO    = 8'hE0;
    localparam logic [7:0] B_APP_HI    = 8'hEF;
    localparam logic [7:0] B_COM       = 8'hFE;
    localparam logic [7:0] B_RIFF0     = 8'h52;

    localparam logic [23:0] TAG_PNG  = "PNG";
    localparam logic [31:0] TAG_TEXT = "tEXt";
    localparam logic [31:0] TAG_ZTXT = "zTXt";
    localparam logic [31:0] TAG_ITXT = "iTXt";
    localparam logic [31:0] TAG_TIME = "tIME";
    localparam logic [31:0] TAG_EXIF = "EXIF";
    localparam logic [31:0] TAG_XMP  = "XMP ";
    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WEBP = "WEBP";

endpackage

// ===== sv/imds_front.sv =====
// imds_front: format detection and chunk/segment parsing, one item per cycle while the queue is not full
// builds at most one queue entry per item; depends on imds_pkg

module imds_front #(
    parameter int HEADER_DEPTH = 12,
    parameter int LENGTH_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic          i_accept,
    input  imds_pkg::t_in i_item,
    output logic          o_push,
    output imds_pkg::t_cmd o_cmd
);
    import imds_pkg::*;

    localparam int WB = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 2;
    localparam int FW = $clog2(HEADER_DEPTH + 1);
    localparam int IW = $clog2(HEADER_DEPTH);

    typedef enum logic [2:0] {
        FMT_DETECT, FMT_PNG, FMT_JPEG, FMT_WEBP, FMT_UNSUP
    } t_fmt;

    typedef enum logic [2:0] {
        PH_DETECT, PH_SEG, PH_HDR, PH_JMARK, PH_JLEN, PH_PASS, PH_DONE
    } t_phase;

    t_fmt                   r_fmt;
    t_phase                 r_phase;
    logic [LENGTH_BITS-1:0] r_pos;
    logic [7:0]             r_store [HEADER_DEPTH];
    logic [FW-1:0]          r_fill;
    logic [32:0]            r_rem;
    logic                   r_keep;
    logic [31:0]            r_file_length;

    t_fmt                   n_fmt;
    t_phase                 n_phase;
    logic [LENGTH_BITS-1:0] n_pos;
    logic [7:0]             n_store [HEADER_DEPTH];
    logic [FW-1:0]          n_fill;
    logic [32:0]            n_rem;
    logic                   n_keep;

    logic [LENGTH_BITS-1:0] sz;
    t_cmd                   v_cmd;

    always_comb begin
        logic [WB-1:0] pos_w;
        logic [WB-1:0] sz_w;
        logic [WB-1:0] v_start;
        logic [7:0]    v_pb [2];
        logic [WB-1:0] v_pp [2];
        logic [1:0]    v_pv;
        logic [3:0]    v_cnt;
        logic [31:0]   v_len;
        logic [32:0]   v_body;
        logic          v_drop;
        logic [7:0]    b;
        logic [7:0]    m;

        sz      = LENGTH_BITS'(r_file_length);
        pos_w   = WB'(r_pos);
        sz_w    = WB'(sz);
        n_fmt   = r_fmt;
        n_phase = r_phase;
        n_fill  = r_fill;
        n_store = r_store;
        n_rem   = r_rem;
        n_keep  = r_keep;
        v_cmd   = '0;
        v_cnt   = '0;
        v_pv    = '0;
        v_pb[0] = '0;
        v_pb[1] = '0;
        v_pp[0] = '0;
        v_pp[1] = '0;
        v_start = '0;
        v_len   = '0;
        v_body  = '0;
        v_drop  = 1'b0;
        b       = i_item.in_byte;
        m       = '0;

        if (r_pos < sz) begin
            case (r_phase)
                PH_DETECT: begin
                    if (n_fill < FW'(HEADER_DEPTH)) begin
                        n_store[n_fill[IW-1:0]] = b;
                        n_fill = n_fill + FW'(1);
                    end
                    if (n_store[0] == B_PNG_MAGIC) begin
                        if (sz_w < WB'(8)) begin
                            n_fmt = FMT_UNSUP; n_phase = PH_DONE; n_fill = '0;
                        end else if (n_fill >= FW'(4)) begin
                            if ({n_store[1], n_store[2], n_store[3]} == TAG_PNG) begin
                                n_fmt = FMT_PNG;
                                for (int i = 0; i < 4; i++) v_cmd.bytes[i] = n_store[i];
                                v_cnt   = 4'd4;
                                n_fill  = '0;
                                n_rem   = 33'd4;
                                n_keep  = 1'b1;
                                n_phase = PH_SEG;
                            end else begin
                                n_fmt = FMT_UNSUP; n_phase = PH_DONE; n_fill = '0;
                            end
                        end
                    end else if (n_store[0] == B_MARK) begin
                        if (sz_w < WB'(3)) begin
                            n_fmt = FMT_UNSUP; n_phase = PH_DONE; n_fill = '0;
                        end else if (n_fill >= FW'(3)) begin
                            if (n_store[1] == B_SOI && n_store[2] == B_MARK) begin
                                n_fmt = FMT_JPEG;
                                v_cmd.bytes[0] = B_MARK;
                                v_cmd.bytes[1] = B_SOI;
                                v_cnt   = 4'd2;
                                n_fill  = '0;
                                n_phase = PH_HDR;
                                v_pv[0] = 1'b1;
                                v_pb[0] = B_MARK;
                                v_pp[0] = WB'(2);
                            end else begin
                                n_fmt = FMT_UNSUP; n_phase = PH_DONE; n_fill = '0;
                            end
                        end
                    end else if (n_store[0] == B_RIFF0) begin
                        if (sz_w < WB'(12)) begin
                            n_fmt = FMT_UNSUP; n_phase = PH_DONE; n_fill = '0;
                        end else if (n_fill >= FW'(12)) begin
                            if ({n_store[0], n_store[1], n_store[2], n_store[3]} == TAG_RIFF &&
                                {n_store[8], n_store[9], n_store[10], n_store[11]} == TAG_WEBP)
                            begin
                                n_fmt = FMT_WEBP;
                                for (int i = 0; i < 12; i++) v_cmd.bytes[i] = n_store[i];
                                v_cnt   = 4'd12;
                                n_fill  = '0;
                                n_phase = PH_HDR;
                            end else begin
                                n_fmt = FMT_UNSUP; n_phase = PH_DONE; n_fill = '0;
                            end
                        end
                    end else begin
                        n_fmt = FMT_UNSUP; n_phase = PH_DONE; n_fill = '0;
                    end
                end
                PH_SEG: begin
                    if (r_keep) begin
                        v_cmd.bytes[0] = b;
                        v_cnt = 4'd1;
                    end
                    if (r_rem != '0) n_rem = r_rem - 33'd1;
                    if (n_rem == '0) n_phase = PH_HDR;
                end
                PH_HDR: begin
                    if (r_fmt == FMT_JPEG) begin
                        v_pv[0] = 1'b1;
                        v_pb[0] = b;
                        v_pp[0] = pos_w;
                    end else if (r_fill == '0 && pos_w + WB'(8) > sz_w) begin
                        n_phase = PH_DONE; n_fill = '0;
                    end else begin
                        if (n_fill < FW'(HEADER_DEPTH)) begin
                            n_store[n_fill[IW-1:0]] = b;
                            n_fill = n_fill + FW'(1);
                        end
                        if (n_fill >= FW'(8)) begin
                            v_start = pos_w - WB'(7);
                            if (r_fmt == FMT_PNG) begin
                                v_len  = {n_store[0], n_store[1], n_store[2], n_store[3]};
                                v_body = {1'b0, v_len} + 33'd4;
                                v_drop = ({n_store[4], n_store[5], n_store[6], n_store[7]}
                                          inside {TAG_TEXT, TAG_ZTXT, TAG_ITXT, TAG_TIME});
                                if (v_start + WB'(12) + WB'(v_len) > sz_w) begin
                                    n_phase = PH_DONE; n_fill = '0;
                                end
                            end else begin
                                v_len  = {n_store[7], n_store[6], n_store[5], n_store[4]};
                                v_body = {1'b0, v_len} + {32'd0, v_len[0]};
                                v_drop = ({n_store[0], n_store[1], n_store[2], n_store[3]}
                                          inside {TAG_EXIF, TAG_XMP});
                                if (v_start + WB'(8) + WB'(v_body) > sz_w) begin
                                    n_phase = PH_DONE; n_fill = '0;
                                end
                            end
                            if (n_phase != PH_DONE) begin
                                if (!v_drop) begin
                                    for (int i = 0; i < 8; i++) v_cmd.bytes[i] = n_store[i];
                                    v_cnt = 4'd8;
                                end
                                n_fill  = '0;
                                n_rem   = v_body;
                                n_keep  = !v_drop;
                                n_phase = (v_body != '0) ? PH_SEG : PH_HDR;
                            end
                        end
                    end
                end
                PH_JMARK: begin
                    v_pv[0] = 1'b1;
                    v_pb[0] = b;
                    v_pp[0] = pos_w;
                end
                PH_JLEN: begin
                    if (n_fill < FW'(HEADER_DEPTH)) begin
                        n_store[n_fill[IW-1:0]] = b;
                        n_fill = n_fill + FW'(1);
                    end
                    if (n_fill >= FW'(4)) begin
                        m       = n_store[1];
                        v_len   = {16'd0, n_store[2], n_store[3]};
                        v_start = pos_w - WB'(3);
                        n_fill  = '0;
                        if (!(m inside {[B_APP_LO:B_APP_HI], B_COM})) begin
                            v_cmd.bytes[0] = B_MARK;
                            v_cmd.bytes[1] = m;
                            v_cnt = 4'd2;
                        end
                        if (v_len >= 32'd2) begin
                            if (!(m inside {[B_APP_LO:B_APP_HI], B_COM})) begin
                                v_cmd.bytes[2] = n_store[2];
                                v_cmd.bytes[3] = n_store[3];
                                v_cnt = 4'd4;
                            end
                            n_rem   = {1'b0, v_len} - 33'd2;
                            n_keep  = !(m inside {[B_APP_LO:B_APP_HI], B_COM});
                            n_phase = (n_rem != '0) ? PH_SEG : PH_HDR;
                        end else begin
                            n_phase = PH_HDR;
                            if (v_len == '0 || !(m inside {[B_APP_LO:B_APP_HI], B_COM})) begin
                                v_pv    = 2'b11;
                                v_pb[0] = n_store[2];
                                v_pp[0] = v_start + WB'(2);
                                v_pb[1] = n_store[3];
                                v_pp[1] = v_start + WB'(3);
                            end else begin
                                v_pv[0] = 1'b1;
                                v_pb[0] = n_store[3];
                                v_pp[0] = v_start + WB'(3);
                            end
                        end
                    end
                end
                PH_PASS: begin
                    v_cmd.bytes[0] = b;
                    v_cnt = 4'd1;
                end
                default: begin
                end
            endcase

            // marker scan steps, up to two per item
            for (int k = 0; k < 2; k++) begin
                if (v_pv[k]) begin
                    if (n_phase == PH_HDR) begin
                        if (v_pp[k] + WB'(2) > sz_w) begin
                            n_phase = PH_DONE; n_fill = '0;
                        end else if (v_pb[k] == B_MARK) begin
                            n_store[0] = B_MARK;
                            n_fill     = FW'(1);
                            n_phase    = PH_JMARK;
                        end
                    end else if (n_phase == PH_JMARK) begin
                        v_start = v_pp[k] - WB'(1);
                        if ((v_pb[k] inside {[B_APP_LO:B_APP_HI], B_COM}) &&
                            v_start + WB'(4) > sz_w) begin
                            n_phase = PH_DONE; n_fill = '0;
                        end else if (v_pb[k] != B_SOS && v_start + WB'(4) <= sz_w) begin
                            if (n_fill < FW'(HEADER_DEPTH)) begin
                                n_store[n_fill[IW-1:0]] = v_pb[k];
                                n_fill = n_fill + FW'(1);
                            end
                            n_phase = PH_JLEN;
                        end else begin
                            v_cmd.bytes[v_cnt]         = B_MARK;
                            v_cmd.bytes[v_cnt + 4'd1]  = v_pb[k];
                            v_cnt   = v_cnt + 4'd2;
                            n_phase = PH_PASS;
                        end
                    end
                end
            end
        end

        n_pos = (r_pos != '1) ? r_pos + LENGTH_BITS'(1) : r_pos;
        v_cmd.cnt = v_cnt;

        if (i_item.in_last) begin
            v_cmd.has_end    = 1'b1;
            v_cmd.end_status = (n_fmt == FMT_PNG || n_fmt == FMT_JPEG || n_fmt == FMT_WEBP)
                               ? ST_SCRUBBED : ST_UNSUPPORTED;
            n_fmt   = FMT_DETECT;
            n_phase = PH_DETECT;
            n_pos   = '0;
            n_fill  = '0;
            n_rem   = '0;
            n_keep  = 1'b0;
        end
    end

    assign o_cmd  = v_cmd;
    assign o_push = i_accept && (v_cmd.cnt != '0 || v_cmd.has_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt         <= FMT_DETECT;
            r_phase       <= PH_DETECT;
            r_pos         <= '0;
            r_fill        <= '0;
            r_rem         <= '0;
            r_keep        <= 1'b0;
            r_file_length <= '0;
        end else begin
            if (i_cfg_wr_en) r_file_length <= i_cfg_wr_data;
            if (i_accept) begin
                r_fmt   <= n_fmt;
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_fill  <= n_fill;
                r_rem   <= n_rem;
                r_keep  <= n_keep;
            end
        end
        if (i_accept) r_store <= n_store;
    end

endmodule

// ===== sv/imds_queue.sv =====
// imds_queue: short queue of parsed entries between parser and output sequencer
// depends on imds_pkg

module imds_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  imds_pkg::t_cmd i_data,
    input  logic           i_pop,
    output imds_pkg::t_cmd o_data,
    output logic           o_empty,
    output logic           o_full
);
    import imds_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (do_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CW'(1);
        end
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ===== sv/imds_back.sv =====
// imds_back: expands queue entries into result items, one per cycle while not stalled, registered output
// depends on imds_pkg

module imds_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  imds_pkg::t_cmd i_q_data,
    output logic           o_q_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output imds_pkg::t_out o_item
);
    import imds_pkg::*;

    t_cmd       r_cur;
    logic       r_cur_v;
    logic [3:0] r_idx;
    logic       r_valid;
    t_out       r_out;

    t_cmd       n_cur;
    logic       n_cur_v;
    logic [3:0] n_idx;
    logic       n_valid;
    t_out       n_out;

    logic       load;
    logic [3:0] last_idx;

    assign load     = !r_valid || !i_stall;
    assign last_idx = r_cur.cnt + {3'd0, r_cur.has_end} - 4'd1;

    always_comb begin
        n_cur   = r_cur;
        n_cur_v = r_cur_v;
        n_idx   = r_idx;
        n_valid = r_valid && i_stall;
        n_out   = r_out;
        o_q_pop = 1'b0;
        if (load && r_cur_v) begin
            n_valid = 1'b1;
            if (r_idx < r_cur.cnt) begin
                n_out.kind      = KIND_DATA;
                n_out.data_byte = r_cur.bytes[r_idx];
                n_out.status    = ST_SCRUBBED;
            end else begin
                n_out.kind      = KIND_END;
                n_out.data_byte = '0;
                n_out.status    = r_cur.end_status;
            end
            n_out.run_last = (r_idx == last_idx);
            n_idx = r_idx + 4'd1;
        end
        if (!r_cur_v || (load && r_idx == last_idx)) begin
            o_q_pop = !i_q_empty;
            n_cur_v = !i_q_empty;
            n_cur   = i_q_data;
            n_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cur_v <= n_cur_v;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

endmodule

// ===== sv/image_metadata_stripper.sv =====
// image_metadata_stripper: top level, parser -> entry queue -> output sequencer
// depends on imds_pkg, imds_front, imds_queue, imds_back
//
//   channel   | handshake          | payload
//   ----------+--------------------+------------------------------
//   input     | i_valid / o_stall  | i_item  (in_byte, in_last)
//   output    | o_valid / i_stall  | o_item  (kind, data_byte, status, run_last)
//   config    | i_cfg_wr_en        | i_cfg_wr_data (file_length)
//
// one input item per cycle while o_stall is low; an item with n results gives n output items
// (header flushes up to 12 bytes plus end item), sent one at a time from the single output register
// up to QUEUE_DEPTH parsed entries wait between parser and output; o_stall when full
// synchronous active-low reset clears parser state, queue and output; no clearing pass
// with an empty queue the first output item passes the queue, the current-entry register and the output register

module image_metadata_stripper #(
    parameter int HEADER_DEPTH = 12,
    parameter int LENGTH_BITS  = 32,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [31:0]    i_cfg_wr_data,
    input  logic           i_valid,
    output logic           o_stall,
    input  imds_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output imds_pkg::t_out o_item
);
    import imds_pkg::*;

    logic accept;
    logic push;
    t_cmd push_cmd;
    logic pop;
    t_cmd head_cmd;
    logic q_empty;
    logic q_full;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    imds_front #(
        .HEADER_DEPTH (HEADER_DEPTH),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_item        (i_item),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    imds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    imds_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (head_cmd),
        .o_q_pop   (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_item    (o_item)
    );

endmodule

// ===== sv/imds_checker.sv =====
// imds_checker: port-level checks on the stripper output channel
// depends on imds_pkg; bound to image_metadata_stripper

module imds_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input imds_pkg::t_out o_item
);
    import imds_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output item changed under stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.kind == KIND_END |-> o_item.run_last && o_item.data_byte == 8'd0)
        else $error("end item malformed");

    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.kind == KIND_DATA |-> o_item.status == ST_SCRUBBED)
        else $error("data item with status set");

endmodule

bind image_metadata_stripper imds_checker u_imds_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
